// File: sv/hdlcd_pkg.sv
package hdlcd_pkg;

    localparam int MAX_FRAME_BYTES = 1024;
    localparam int CRC_LEN         = 4;
    localparam int LEN_W           = 11;
    localparam int MIN_W           = 7;

    localparam logic [7:0]  FLAG_BYTE = 8'h7E;
    localparam logic [7:0]  ESC_BYTE  = 8'h7D;
    localparam logic [7:0]  ESC_MASK  = 8'h20;
    localparam logic [31:0] CRC_POLY  = 32'hEDB88320;
    localparam logic [31:0] CRC_INIT  = 32'hFFFFFFFF;
    localparam logic [6:0]  MIN_RESET = 7'd6;

    localparam logic [LEN_W-1:0] MAX_COUNT = LEN_W'(MAX_FRAME_BYTES);
    localparam logic [LEN_W-1:0] CRC_COUNT = LEN_W'(CRC_LEN);

    typedef enum logic {
        OP_DATA  = 1'b0,
        OP_CLOSE = 1'b1
    } op_t;

    typedef enum logic [2:0] {
        ST_GOOD  = 3'd0,
        ST_ESC   = 3'd1,
        ST_MALF  = 3'd2,
        ST_SHORT = 3'd3,
        ST_CRC   = 3'd4
    } status_t;

    typedef struct packed {
        op_t              op;
        logic [7:0]       data;
        logic             emit;
        logic             esc;
        logic             malf;
        logic [LEN_W-1:0] len;
    } item_t;

    function automatic logic [31:0] crc_byte(input logic [31:0] crc_in, input logic [7:0] b);
        logic [31:0] c;
        c = crc_in ^ {24'd0, b};
        for (int k = 0; k < 8; k++) begin
            if (c[0]) begin
                c = (c >> 1) ^ CRC_POLY;
            end else begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

endpackage

// File: sv/hdlcd_front.sv
module hdlcd_front (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic [7:0]           s_rx_byte,
    input  logic                 q_full,
    output logic                 q_push,
    output hdlcd_pkg::item_t     q_item
);
    import hdlcd_pkg::*;

    logic             in_frame_reg, in_frame_next;
    logic             esc_reg, esc_next;
    logic             malf_reg, malf_next;
    logic [LEN_W-1:0] cnt_reg, cnt_next;
    logic             accept;
    logic             need_push;

    assign s_ready = !q_full;
    assign accept  = s_valid && s_ready;
    assign q_push  = accept && need_push;

    always_comb begin
        in_frame_next = in_frame_reg;
        esc_next      = esc_reg;
        malf_next     = malf_reg;
        cnt_next      = cnt_reg;
        need_push     = 1'b0;
        q_item.op     = OP_DATA;
        q_item.data   = esc_reg ? (s_rx_byte ^ ESC_MASK) : s_rx_byte;
        q_item.emit   = (cnt_reg >= CRC_COUNT);
        q_item.esc    = esc_reg;
        q_item.malf   = malf_reg;
        q_item.len    = cnt_reg;
        if (accept) begin
            priority if (s_rx_byte == FLAG_BYTE) begin
                if (in_frame_reg && (cnt_reg != '0)) begin
                    need_push = 1'b1;
                    q_item.op = OP_CLOSE;
                end
                in_frame_next = 1'b1;
                esc_next      = 1'b0;
                malf_next     = 1'b0;
                cnt_next      = '0;
            end else if (!in_frame_reg) begin
                in_frame_next = 1'b0;
            end else if (s_rx_byte == ESC_BYTE) begin
                if (esc_reg) begin
                    malf_next = 1'b1;
                end
                esc_next = !esc_reg;
            end else if (cnt_reg < MAX_COUNT) begin
                need_push = 1'b1;
                cnt_next  = cnt_reg + LEN_W'(1);
                esc_next  = 1'b0;
            end else begin
                malf_next = 1'b1;
                esc_next  = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_frame_reg <= 1'b0;
            esc_reg      <= 1'b0;
            malf_reg     <= 1'b0;
            cnt_reg      <= '0;
        end else begin
            in_frame_reg <= in_frame_next;
            esc_reg      <= esc_next;
            malf_reg     <= malf_next;
            cnt_reg      <= cnt_next;
        end
    end

endmodule

// File: sv/hdlcd_queue.sv
module hdlcd_queue (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             push,
    input  hdlcd_pkg::item_t push_item,
    output logic             full,
    input  logic             pop,
    output logic             empty,
    output hdlcd_pkg::item_t pop_item
);
    import hdlcd_pkg::*;

    item_t      mem_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;

    assign full     = (count_reg == 2'd2);
    assign empty    = (count_reg == 2'd0);
    assign pop_item = mem_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_item;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

// File: sv/hdlcd_back.sv
module hdlcd_back (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic [hdlcd_pkg::MIN_W-1:0]   min_frame_bytes,
    input  logic                          q_empty,
    input  hdlcd_pkg::item_t              q_item,
    output logic                          q_pop,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic                          m_kind,
    output logic [7:0]                    m_payload_byte,
    output logic [2:0]                    m_frame_status,
    output logic [hdlcd_pkg::LEN_W-1:0]   m_frame_length
);
    import hdlcd_pkg::*;

    logic [7:0]       tap_reg [CRC_LEN];
    logic [31:0]      crc_reg, crc_next;
    logic             out_valid_reg, out_valid_next;
    logic             kind_reg, kind_next;
    logic [7:0]       byte_reg, byte_next;
    status_t          status_reg, status_next;
    logic [LEN_W-1:0] len_reg, len_next;
    logic [31:0]      expect_crc;
    logic             too_short;

    assign q_pop      = !q_empty && (!out_valid_reg || m_ready);
    assign expect_crc = {tap_reg[3], tap_reg[2], tap_reg[1], tap_reg[0]};
    assign too_short  = (q_item.len < {{(LEN_W-MIN_W){1'b0}}, min_frame_bytes})
                        || (q_item.len < CRC_COUNT);

    assign m_valid        = out_valid_reg;
    assign m_kind         = kind_reg;
    assign m_payload_byte = byte_reg;
    assign m_frame_status = status_reg;
    assign m_frame_length = len_reg;

    always_comb begin
        crc_next       = crc_reg;
        out_valid_next = out_valid_reg && !m_ready;
        kind_next      = kind_reg;
        byte_next      = byte_reg;
        status_next    = status_reg;
        len_next       = len_reg;
        if (q_pop) begin
            unique case (q_item.op)
                OP_DATA: begin
                    if (q_item.emit) begin
                        crc_next       = crc_byte(crc_reg, tap_reg[0]);
                        out_valid_next = 1'b1;
                        kind_next      = 1'b0;
                        byte_next      = tap_reg[0];
                        status_next    = ST_GOOD;
                        len_next       = '0;
                    end
                end
                OP_CLOSE: begin
                    crc_next       = CRC_INIT;
                    out_valid_next = 1'b1;
                    kind_next      = 1'b1;
                    byte_next      = 8'd0;
                    len_next       = q_item.len;
                    priority if (q_item.esc) begin
                        status_next = ST_ESC;
                    end else if (q_item.malf) begin
                        status_next = ST_MALF;
                    end else if (too_short) begin
                        status_next = ST_SHORT;
                    end else if ((crc_reg ^ CRC_INIT) == expect_crc) begin
                        status_next = ST_GOOD;
                    end else begin
                        status_next = ST_CRC;
                    end
                end
                default: begin
                    crc_next = crc_reg;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (q_pop && (q_item.op == OP_DATA)) begin
            for (int i = 0; i < CRC_LEN - 1; i++) begin
                tap_reg[i] <= tap_reg[i+1];
            end
            tap_reg[CRC_LEN-1] <= q_item.data;
        end
        kind_reg   <= kind_next;
        byte_reg   <= byte_next;
        status_reg <= status_next;
        len_reg    <= len_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            crc_reg       <= CRC_INIT;
            out_valid_reg <= 1'b0;
        end else begin
            crc_reg       <= crc_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

// File: sv/hdlc_deframer_crc32_check_unit.sv
// Channel   Direction  Beat payload
// s_        in         rx_byte (8): one raw received byte
// m_        out        kind (1), payload_byte (8), frame_status (3), frame_length (11)
// cfg_      in         data (7): min_frame_bytes
//
// One byte per cycle sustained while m_ready stays high; results pass the queue and the output register.
// The front classifies and unescapes bytes, a two-beat queue feeds the back, which runs the
// tail delay line, the byte-wide CRC-32 update and the verdict in its output register.
// A stall on m_ fills the queue, then drops s_ready; cfg_ready is always high.
// Synchronous active-low reset clears frame state; min_frame_bytes resets to 6.
module hdlc_deframer_crc32_check_unit (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic [7:0]                  s_rx_byte,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic                        m_kind,
    output logic [7:0]                  m_payload_byte,
    output logic [2:0]                  m_frame_status,
    output logic [hdlcd_pkg::LEN_W-1:0] m_frame_length,
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [hdlcd_pkg::MIN_W-1:0] cfg_data
);
    import hdlcd_pkg::*;

    logic [MIN_W-1:0] min_reg;
    logic             q_push, q_full, q_pop, q_empty;
    item_t            push_item, pop_item;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            min_reg <= MIN_RESET;
        end else if (cfg_valid && cfg_ready) begin
            min_reg <= cfg_data;
        end
    end

    hdlcd_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_rx_byte (s_rx_byte),
        .q_full    (q_full),
        .q_push    (q_push),
        .q_item    (push_item)
    );

    hdlcd_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_item (push_item),
        .full      (q_full),
        .pop       (q_pop),
        .empty     (q_empty),
        .pop_item  (pop_item)
    );

    hdlcd_back u_back (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .min_frame_bytes (min_reg),
        .q_empty         (q_empty),
        .q_item          (pop_item),
        .q_pop           (q_pop),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_kind          (m_kind),
        .m_payload_byte  (m_payload_byte),
        .m_frame_status  (m_frame_status),
        .m_frame_length  (m_frame_length)
    );

endmodule
